@@ rtl/psg_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psg_pkg
// Shared types, register codes and the attenuation table of the sound generator.
// ----------------------------------------------------------------------------
package psg_pkg;

  localparam int FRACTION_BITS_DEFAULT  = 16;
  localparam int COUNTER_WIDTH_DEFAULT  = 28;
  localparam int LFSR_MAX_WIDTH_DEFAULT = 16;
  localparam int FULL_SCALE_DEFAULT     = 8191;

  localparam int AMP_BITS    = 13;
  localparam int PERIOD_BITS = 10;

  localparam logic [23:0] CLOCKS_PER_SAMPLE_RESET = 24'd332557;
  localparam logic [4:0]  NOISE_WIDTH_RESET       = 5'd16;
  localparam logic [15:0] NOISE_TAPS_RESET        = 16'd9;
  localparam logic [3:0]  ATTEN_SILENT            = 4'hF;

  // latch target code for the noise control register
  localparam logic [2:0]  TGT_NOISE_CTRL = 3'd6;
  // noise rate code that follows tone 2
  localparam logic [1:0]  NOISE_RATE_TONE2 = 2'd3;

  typedef enum logic [1:0] {
    CFG_CLOCKS_PER_SAMPLE = 2'd0,
    CFG_NOISE_WIDTH       = 2'd1,
    CFG_NOISE_TAPS        = 2'd2
  } psg_cfg_idx_t;

  typedef struct packed {
    logic [23:0] clocks_per_sample;
    logic [4:0]  noise_width;
    logic [15:0] noise_taps;
  } psg_cfg_t;

  typedef struct packed {
    logic [2:0][PERIOD_BITS-1:0] tone_period;
    logic [3:0][3:0]             atten;
    logic [2:0]                  noise_ctrl;
  } psg_voice_t;

  // 10^(-k/10) in 1.16 fixed point; last entry is silence
  function automatic logic [16:0] level_ratio(input logic [3:0] k);
    logic [16:0] r;
    case (k)
      4'd0:    r = 17'd65536;
      4'd1:    r = 17'd52057;
      4'd2:    r = 17'd41350;
      4'd3:    r = 17'd32846;
      4'd4:    r = 17'd26090;
      4'd5:    r = 17'd20724;
      4'd6:    r = 17'd16462;
      4'd7:    r = 17'd13076;
      4'd8:    r = 17'd10387;
      4'd9:    r = 17'd8250;
      4'd10:   r = 17'd6554;
      4'd11:   r = 17'd5206;
      4'd12:   r = 17'd4135;
      4'd13:   r = 17'd3285;
      4'd14:   r = 17'd2609;
      default: r = 17'd0;
    endcase
    return r;
  endfunction

  // full scale is a constant, so this folds to a 16-entry table
  function automatic logic [AMP_BITS-1:0] amplitude(input logic [3:0] att,
                                                    input int full_scale);
    logic [31:0] p;
    p = 32'(full_scale) * {15'd0, level_ratio(att)};
    return AMP_BITS'((p + 32'd32768) >> 16);
  endfunction

endpackage

@@ rtl/psg_regs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psg_regs
// Configuration registers and the latch/data byte decoder for voice registers.
// ----------------------------------------------------------------------------
module psg_regs import psg_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_data,
  input  logic        wr_en,
  input  logic [7:0]  wr_data,
  output psg_cfg_t    cfg,
  output psg_voice_t  voice,
  output logic        reseed
);

  logic [2:0] latched;
  logic [2:0] tgt;

  // target of this byte: fresh for a latch byte, held for a data byte
  assign tgt    = wr_data[7] ? wr_data[6:4] : latched;
  assign reseed = wr_en && !tgt[0] && (tgt == TGT_NOISE_CTRL);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.clocks_per_sample <= CLOCKS_PER_SAMPLE_RESET;
      cfg.noise_width       <= NOISE_WIDTH_RESET;
      cfg.noise_taps        <= NOISE_TAPS_RESET;
    end else if (cfg_we) begin
      unique case (psg_cfg_idx_t'(cfg_index))
        CFG_CLOCKS_PER_SAMPLE: cfg.clocks_per_sample <= cfg_data;
        CFG_NOISE_WIDTH:       cfg.noise_width       <= cfg_data[4:0];
        CFG_NOISE_TAPS:        cfg.noise_taps        <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      latched          <= 3'd0;
      voice.tone_period <= '0;
      voice.atten       <= {4{ATTEN_SILENT}};
      voice.noise_ctrl  <= 3'd0;
    end else if (wr_en) begin
      if (wr_data[7]) begin
        latched <= wr_data[6:4];
      end
      if (tgt[0]) begin
        voice.atten[tgt[2:1]] <= wr_data[3:0];
      end else if (tgt == TGT_NOISE_CTRL) begin
        voice.noise_ctrl <= wr_data[2:0];
      end else if (wr_data[7]) begin
        voice.tone_period[tgt[2:1]][3:0] <= wr_data[3:0];
      end else begin
        voice.tone_period[tgt[2:1]][9:4] <= wr_data[5:0];
      end
    end
  end

endmodule

@@ rtl/psg_voices.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psg_voices
// Tone and noise phase counters, noise shift register and the output mixer.
// ----------------------------------------------------------------------------
module psg_voices import psg_pkg::*; #(
  parameter int FRACTION_BITS        = FRACTION_BITS_DEFAULT,
  parameter int COUNTER_WIDTH        = COUNTER_WIDTH_DEFAULT,
  parameter int LFSR_MAX_WIDTH       = LFSR_MAX_WIDTH_DEFAULT,
  parameter int FULL_SCALE_AMPLITUDE = FULL_SCALE_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  psg_cfg_t           cfg,
  input  psg_voice_t         voice,
  input  logic               reseed,
  input  logic               tick_en,
  output logic signed [15:0] sample_next
);

  localparam int CW  = COUNTER_WIDTH;
  localparam int FB  = FRACTION_BITS;
  localparam int LW  = LFSR_MAX_WIDTH;
  localparam int EW0 = (CW > 25) ? CW : 25;
  localparam int EW1 = (FB + PERIOD_BITS + 3 > EW0) ? FB + PERIOD_BITS + 3 : EW0;
  localparam int EW  = EW1 + 2;
  localparam logic signed [EW-1:0] CNT_HI = {{(EW-CW+1){1'b0}}, {(CW-1){1'b1}}};
  localparam logic signed [EW-1:0] CNT_LO = ~CNT_HI;
  localparam int RESET_W = (16 < LW) ? 16 : LW;
  localparam logic [LW-1:0] RESET_SEED = LW'(1) << (RESET_W - 1);

  logic signed [CW-1:0] cnt [4];
  logic signed [CW-1:0] cnt_next [4];
  logic [3:0]           phase;
  logic [3:0]           phase_next;
  logic [LW-1:0]        lfsr;
  logic [LW-1:0]        lfsr_next;
  logic [5:0]           eff_w;
  logic [LW-1:0]        seed;
  logic [LW:0]          mask_x;
  logic [LW-1:0]        taps_x;
  logic                 feed;

  function automatic logic signed [CW-1:0] sat(input logic signed [EW-1:0] v);
    logic signed [CW-1:0] r;
    if (v > CNT_HI) r = CNT_HI[CW-1:0];
    else if (v < CNT_LO) r = CNT_LO[CW-1:0];
    else r = v[CW-1:0];
    return r;
  endfunction

  function automatic logic signed [EW-1:0] ext(input logic signed [CW-1:0] v);
    return {{(EW-CW){v[CW-1]}}, v};
  endfunction

  // shift register length, clamped to [2, LW]
  always_comb begin
    if (cfg.noise_width < 5'd2) eff_w = 6'd2;
    else if ({1'b0, cfg.noise_width} > 6'(LW)) eff_w = 6'(LW);
    else eff_w = {1'b0, cfg.noise_width};
  end

  assign seed   = LW'(1) << (eff_w - 6'd1);
  assign mask_x = ({{LW{1'b0}}, 1'b1} << eff_w) - {{LW{1'b0}}, 1'b1};
  assign taps_x = LW'(cfg.noise_taps);
  assign feed   = voice.noise_ctrl[2] ? ^(lfsr & taps_x) : lfsr[0];

  always_comb begin
    logic signed [CW-1:0] c;
    logic signed [EW-1:0] step_e;
    logic [7:0]           nrel;
    step_e = {{(EW-24){1'b0}}, cfg.clocks_per_sample};
    nrel   = 8'h10 << voice.noise_ctrl[1:0];
    phase_next = phase;
    lfsr_next  = lfsr;
    for (int i = 0; i < 3; i++) begin
      c = sat(ext(cnt[i]) - step_e);
      if (c <= 0) begin
        if (voice.tone_period[i] < 10'd7) phase_next[i] = 1'b1;
        else phase_next[i] = ~phase[i];
        c = sat(ext(c) + {{(EW-PERIOD_BITS-FB){1'b0}}, voice.tone_period[i], {FB{1'b0}}});
      end
      cnt_next[i] = c;
    end
    c = sat(ext(cnt[3]) - step_e);
    if (c < 0) begin
      phase_next[3] = ~phase[3];
      if (voice.noise_ctrl[1:0] == NOISE_RATE_TONE2) c = cnt_next[2];
      else c = sat(ext(c) + {{(EW-8-FB){1'b0}}, nrel, {FB{1'b0}}});
      if (phase_next[3]) begin
        lfsr_next = ((lfsr >> 1) | (LW'(feed) << (eff_w - 6'd1))) & mask_x[LW-1:0];
      end
    end
    cnt_next[3] = c;
  end

  // mix with this tick's updated phases
  always_comb begin
    logic signed [15:0] acc;
    logic signed [15:0] a;
    acc = '0;
    for (int i = 0; i < 4; i++) begin
      a = signed'({{(16-AMP_BITS){1'b0}},
                   amplitude(voice.atten[i], FULL_SCALE_AMPLITUDE)});
      if (i < 3) acc = phase_next[i] ? acc + a : acc - a;
      else acc = lfsr_next[0] ? acc + a : acc - a;
    end
    sample_next = acc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) cnt[i] <= '0;
      phase <= 4'hF;
      lfsr  <= RESET_SEED;
    end else if (tick_en) begin
      for (int i = 0; i < 4; i++) cnt[i] <= cnt_next[i];
      phase <= phase_next;
      lfsr  <= lfsr_next;
    end else if (reseed) begin
      lfsr <= seed;
    end
  end

endmodule

@@ rtl/psg_tone_noise_generator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psg_tone_noise_generator
// Four-voice sound generator: three square tones, one noise voice, mixed.
// ----------------------------------------------------------------------------
// Input channel (item_valid / item_stall, func, data): each word is either a
// register byte (func = 0, latch/data byte in data) or a sample tick
// (func = 1). A register byte gives no output word; a tick gives one.
// Output channel (sample_valid / sample_stall, sample): signed 16-bit mix.
// Path: a word is registered at the input and handled from the input register;
// a tick's sample is loaded into the output register at the edge that ends
// the cycle in which it is handled, and sample_valid rises at that edge.
// Throughput: one word per cycle while no tick waits on the output, set by
// the single update of all four counters between input and output registers.
// Stalls: register bytes keep flowing while the output waits; a tick waits
// in the input register until the output register is free, and item_stall
// is raised while it waits.
// Reset: all voices silent, counters zero, phases high, noise register
// seeded; config registers return to their defaults.
// Config writes (cfg_we, cfg_index, cfg_data) land at once; index 3 is ignored.
// ----------------------------------------------------------------------------
module psg_tone_noise_generator import psg_pkg::*; #(
  parameter int FRACTION_BITS        = FRACTION_BITS_DEFAULT,
  parameter int COUNTER_WIDTH        = COUNTER_WIDTH_DEFAULT,
  parameter int LFSR_MAX_WIDTH       = LFSR_MAX_WIDTH_DEFAULT,
  parameter int FULL_SCALE_AMPLITUDE = FULL_SCALE_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_stall,
  input  logic               func,
  input  logic [7:0]         data,
  output logic               sample_valid,
  input  logic               sample_stall,
  output logic signed [15:0] sample,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [23:0]        cfg_data
);

  // input register
  logic       s1_valid;
  logic       s1_func;
  logic [7:0] s1_data;

  logic       out_free;
  logic       advance;
  logic       tick_en;
  logic       wr_en;

  psg_cfg_t           cfg;
  psg_voice_t         voice;
  logic               reseed;
  logic signed [15:0] sample_next;

  // output register can take a word this cycle
  assign out_free   = !sample_valid || !sample_stall;
  // register bytes never wait; ticks need a free output slot
  assign advance    = s1_valid && (!s1_func || out_free);
  assign tick_en    = advance && s1_func;
  assign wr_en      = advance && !s1_func;
  assign item_stall = s1_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!item_stall) begin
      s1_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      s1_func <= func;
      s1_data <= data;
    end
  end

  psg_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .wr_en     (wr_en),
    .wr_data   (s1_data),
    .cfg       (cfg),
    .voice     (voice),
    .reseed    (reseed)
  );

  psg_voices #(
    .FRACTION_BITS        (FRACTION_BITS),
    .COUNTER_WIDTH        (COUNTER_WIDTH),
    .LFSR_MAX_WIDTH       (LFSR_MAX_WIDTH),
    .FULL_SCALE_AMPLITUDE (FULL_SCALE_AMPLITUDE)
  ) u_voices (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .voice       (voice),
    .reseed      (reseed),
    .tick_en     (tick_en),
    .sample_next (sample_next)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_valid <= 1'b0;
    end else if (tick_en) begin
      sample_valid <= 1'b1;
    end else if (!sample_stall) begin
      sample_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tick_en) begin
      sample <= sample_next;
    end
  end

`ifndef SYNTHESIS
  // a handled tick always lands in the output register
  a_tick_out: assert property (@(posedge clk) disable iff (rst)
    tick_en |=> sample_valid)
    else $error("tick did not produce a sample");

  // a register byte never creates an output word
  a_write_silent: assert property (@(posedge clk) disable iff (rst)
    (wr_en && !sample_valid) |=> !sample_valid)
    else $error("register byte produced a sample");

  // input only waits on a tick blocked by a full, stalled output
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> (s1_valid && s1_func && sample_valid && sample_stall))
    else $error("input stalled without cause");

  // a tick is never handled while the output holds an untaken word
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    tick_en |-> out_free)
    else $error("sample overwritten");
`endif

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the four-voice tone/noise sound generator.
// ----------------------------------------------------------------------------
// A short table of directed register bytes and ticks runs first. A few of its
// samples are typed in by hand; the rest are checked against a cycle-free
// model of the voices kept in this file. Random phases follow. Each phase
// runs under its own rate, noise width and tap setting. All but phase 2 run
// with random gaps on the input side and random stalls on the output side.
// One phase holds the output off long enough to back up the input. Another
// pauses the sender until every sample owed has come back.
// ----------------------------------------------------------------------------
module tb_top;
  import psg_pkg::*;

  localparam longint CNT_MAX = (longint'(1) << (COUNTER_WIDTH_DEFAULT - 1)) - 1;
  localparam longint CNT_MIN = -CNT_MAX - 1;
  localparam longint ONE_FX  = longint'(1) << FRACTION_BITS_DEFAULT;
  // index past the last register; the block must ignore it
  localparam logic [1:0] CFG_UNUSED_IDX = 2'd3;
  localparam int PHASE_WORDS = 200;

  // DUT ports; the inputs are driven to known values from time zero
  logic               clk          = 1'b0;
  logic               rst          = 1'b1;
  logic               item_valid   = 1'b0;
  logic               item_stall;
  logic               func         = 1'b0;
  logic [7:0]         data         = 8'h00;
  logic               sample_valid;
  logic               sample_stall = 1'b0;
  logic signed [15:0] sample;
  logic               cfg_we       = 1'b0;
  logic [1:0]         cfg_index    = 2'd0;
  logic [23:0]        cfg_data     = 24'd0;

  always #4 clk = ~clk;

  psg_tone_noise_generator u_top (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .func         (func),
    .data         (data),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // --------------------------------------------------------------------------
  // Voice model: register file, counters, phases and noise shift register
  // --------------------------------------------------------------------------
  // 10^(-k/10) in 1.16 fixed point; attenuation 15 is silence
  int unsigned att_q16 [16] = '{65536, 52057, 41350, 32846, 26090, 20724, 16462,
                                13076, 10387, 8250, 6554, 5206, 4135, 3285,
                                2609, 0};

  logic [23:0] m_rate;
  logic [4:0]  m_nwidth;
  logic [15:0] m_taps;
  logic [9:0]  m_period [3];
  logic [3:0]  m_atten [4];
  logic [2:0]  m_nctl;
  logic [2:0]  m_latch;
  longint      m_count [4];
  bit          m_high [4];
  logic [15:0] m_lfsr;

  // samples owed by the block, oldest first
  logic signed [15:0] owed_samples [$];

  int  mismatches = 0;
  bit  idle_on    = 1'b1;   // random gaps/stalls enabled for this phase
  bit  hold_req   = 1'b0;   // ask the output side for one long hold-off
  int  stall_left = 0;
  int  stall_len;
  logic signed [15:0] got_gold;

  function automatic longint clamp_count(longint v);
    if (v > CNT_MAX) return CNT_MAX;
    if (v < CNT_MIN) return CNT_MIN;
    return v;
  endfunction

  // width of the shift register after clamping to 2..max
  function automatic int lfsr_bits();
    int w;
    w = m_nwidth;
    if (w < 2) w = 2;
    if (w > LFSR_MAX_WIDTH_DEFAULT) w = LFSR_MAX_WIDTH_DEFAULT;
    return w;
  endfunction

  function automatic int level_amp(logic [3:0] a);
    longint p;
    p = longint'(FULL_SCALE_DEFAULT) * att_q16[a];
    return int'((p + 32768) >>> 16);
  endfunction

  task automatic reset_voices();
    m_rate   = CLOCKS_PER_SAMPLE_RESET;
    m_nwidth = NOISE_WIDTH_RESET;
    m_taps   = NOISE_TAPS_RESET;
    m_nctl   = 3'd0;
    m_latch  = 3'd0;
    for (int i = 0; i < 3; i++) m_period[i] = '0;
    for (int i = 0; i < 4; i++) begin
      m_atten[i] = ATTEN_SILENT;
      m_count[i] = 0;
      m_high[i]  = 1'b1;
    end
    m_lfsr = 16'(1 << (lfsr_bits() - 1));
  endtask

  task automatic set_reg(logic [1:0] idx, logic [23:0] val);
    case (idx)
      CFG_CLOCKS_PER_SAMPLE: m_rate   = val;
      CFG_NOISE_WIDTH:       m_nwidth = val[4:0];
      CFG_NOISE_TAPS:        m_taps   = val[15:0];
      default: ;
    endcase
  endtask

  // latch byte (bit 7 set) retargets, data byte reuses the last target
  task automatic apply_reg_byte(logic [7:0] d);
    logic [2:0] t;
    if (d[7]) m_latch = d[6:4];
    t = m_latch;
    if (t[0]) begin
      m_atten[t[2:1]] = d[3:0];
    end else if (t == TGT_NOISE_CTRL) begin
      m_nctl = d[2:0];
      m_lfsr = 16'(1 << (lfsr_bits() - 1));
    end else if (d[7]) begin
      m_period[t[2:1]][3:0] = d[3:0];
    end else begin
      m_period[t[2:1]][9:4] = d[5:0];
    end
  endtask

  // one sample tick: step all counters, return the mix
  function automatic logic signed [15:0] mix_tick();
    longint c;
    int sum, w, amp;
    int unsigned mask, shifted;
    logic feed;
    sum = 0;
    for (int ch = 0; ch < 3; ch++) begin
      c = clamp_count(m_count[ch] - longint'(m_rate));
      if (c <= 0) begin
        // very short periods park the tone high instead of toggling
        if (m_period[ch] < 10'd7) m_high[ch] = 1'b1;
        else m_high[ch] = ~m_high[ch];
        c = clamp_count(c + longint'(m_period[ch]) * ONE_FX);
      end
      m_count[ch] = c;
      amp = level_amp(m_atten[ch]);
      sum += m_high[ch] ? amp : -amp;
    end
    c = clamp_count(m_count[3] - longint'(m_rate));
    if (c < 0) begin
      m_high[3] = ~m_high[3];
      // rate code 3 follows tone 2's freshly updated counter
      if (m_nctl[1:0] == NOISE_RATE_TONE2) c = m_count[2];
      else c = clamp_count(c + longint'(16 << m_nctl[1:0]) * ONE_FX);
      if (m_high[3]) begin
        w = lfsr_bits();
        feed = m_nctl[2] ? ^(m_lfsr & m_taps) : m_lfsr[0];
        mask = (32'd1 << w) - 1;
        shifted = ((32'(m_lfsr) >> 1) | (32'(feed) << (w - 1))) & mask;
        m_lfsr = shifted[15:0];
      end
    end
    m_count[3] = c;
    amp = level_amp(m_atten[3]);
    sum += m_lfsr[0] ? amp : -amp;
    return 16'(sum);
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  // mostly no gap, often short, now and then long
  function automatic int pick_gap();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Offer one word, wait for the handshake, then update the model.
  // valid stays high into the next word when no gap is picked.
  task automatic send_word(bit fn, logic [7:0] d, bit typed,
                           logic signed [15:0] typed_val);
    int gap;
    logic signed [15:0] p;
    @(negedge clk);
    item_valid <= 1'b1;
    func       <= fn;
    data       <= d;
    do @(posedge clk); while (item_stall);
    if (fn) begin
      p = mix_tick();
      owed_samples.push_back(typed ? typed_val : p);
    end else begin
      apply_reg_byte(d);
    end
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic stop_input();
    @(negedge clk);
    item_valid <= 1'b0;
  endtask

  task automatic wait_owed_empty();
    while (owed_samples.size() != 0) @(posedge clk);
  endtask

  // idle point: nothing owed, and a register byte still in the pipe has
  // had time to land
  task automatic settle();
    stop_input();
    wait_owed_empty();
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [23:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    set_reg(idx, val);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Directed table
  // --------------------------------------------------------------------------
  typedef struct {
    bit                 fn;
    logic [7:0]         d;
    bit                 typed;
    logic signed [15:0] val;
  } row_t;

  row_t dir_rows [$];

  task automatic add_row(bit fn, logic [7:0] d, bit typed = 1'b0,
                         logic signed [15:0] val = 16'sd0);
    row_t r;
    r.fn = fn; r.d = d; r.typed = typed; r.val = val;
    dir_rows.push_back(r);
  endtask

  task automatic build_rows();
    add_row(1, 8'h00, 1, 16'sd0);      // after reset every voice is silent
    add_row(0, 8'h90);                 // tone 0 full volume
    add_row(1, 8'hFF, 1, 16'sd8191);   // period 0 parks tone 0 high; data ignored
    add_row(0, 8'h9F);                 // tone 0 silent again
    add_row(1, 8'h5A, 1, 16'sd0);
    add_row(0, 8'h80);                 // tone 0 period low nibble 0
    add_row(0, 8'h3F);                 // data byte: high bits -> 0x3F0
    add_row(0, 8'h8F);                 // period now 0x3FF, the maximum
    add_row(0, 8'h90);
    add_row(1, 8'h00);
    add_row(0, 8'hA7);                 // tone 1 period 7: first toggling value
    add_row(0, 8'h00);
    add_row(0, 8'hB1);                 // latch tone 1 attenuation
    add_row(0, 8'h7E);                 // data byte on attenuation target -> 14
    add_row(0, 8'hC6);                 // tone 2 period 6, held high
    add_row(0, 8'hD0);
    add_row(1, 8'h33);
    add_row(0, 8'hE4);                 // white noise, fastest rate, reseeds
    add_row(0, 8'hF0);                 // noise full volume
    add_row(1, 8'h00);
    add_row(1, 8'hC3);
    add_row(0, 8'h07);                 // data byte to noise attenuation -> 7
    add_row(1, 8'h00);
    add_row(0, 8'hE3);                 // periodic noise following tone 2
    add_row(1, 8'h81);
  endtask

  // --------------------------------------------------------------------------
  // Random phases
  // --------------------------------------------------------------------------
  task automatic set_phase_regs(int ph);
    logic [23:0] rate, wid, taps;
    case (ph)
      0: begin rate = CLOCKS_PER_SAMPLE_RESET; wid = 24'd16; taps = 24'd9; end
      1: begin rate = 24'hFFFFFF; wid = 24'd2;  taps = 24'h00FFFF; end
      2: begin rate = 24'd0;      wid = 24'd0;  taps = 24'h000000; end   // frozen counters
      3: begin rate = 24'd1;      wid = 24'd31; taps = 24'h008001; end   // width clamps high
      4: begin
        rate = 24'($urandom_range(1, 2000000));
        wid  = {19'($urandom), 5'($urandom_range(2, 16))};
        taps = 24'($urandom);
      end
      default: begin
        rate = 24'd65536;
        wid  = {19'($urandom), 5'd1};                                  // width clamps low
        taps = 24'($urandom);
      end
    endcase
    write_reg(CFG_CLOCKS_PER_SAMPLE, rate);
    write_reg(CFG_NOISE_WIDTH, wid);
    write_reg(CFG_NOISE_TAPS, taps);
    if (ph == 4) write_reg(CFG_UNUSED_IDX, 24'($urandom));
  endtask

  task automatic run_phase(int ph);
    int r;
    idle_on = (ph != 2);
    for (int i = 0; i < PHASE_WORDS; i++) begin
      if (ph == 1 && i == 100) hold_req = 1'b1;
      if (ph == 3 && i == 100) begin
        stop_input();
        wait_owed_empty();
      end
      r = $urandom_range(0, 99);
      if (r < 40) begin
        send_word(1'b1, 8'($urandom), 1'b0, 16'sd0);
      end else if (r < 70) begin
        // latch followed by a data byte to the same target
        send_word(1'b0, {1'b1, 7'($urandom)}, 1'b0, 16'sd0);
        send_word(1'b0, {1'b0, 7'($urandom)}, 1'b0, 16'sd0);
        i++;
      end else begin
        send_word(1'b0, 8'($urandom), 1'b0, 16'sd0);
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Output side: stalls and checking
  // --------------------------------------------------------------------------
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        // long hold-off while the sender keeps going; ticks back up
        hold_req = 1'b0;
        sample_stall <= 1'b1;
        repeat (80) @(posedge clk);
      end else if (stall_left > 0) begin
        stall_left--;
      end else begin
        stall_len = pick_gap();
        sample_stall <= (stall_len != 0);
        stall_left = (stall_len > 0) ? stall_len - 1 : 0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && sample_valid && !sample_stall) begin
      if (owed_samples.size() == 0) begin
        if (mismatches < 10)
          $display("ERROR: sample %0d with none owed", sample);
        mismatches++;
      end else begin
        got_gold = owed_samples.pop_front();
        if (sample !== got_gold) begin
          if (mismatches < 10)
            $display("ERROR: sample got %0d, wanted %0d", sample, got_gold);
          mismatches++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    reset_voices();
    build_rows();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i])
      send_word(dir_rows[i].fn, dir_rows[i].d, dir_rows[i].typed, dir_rows[i].val);

    for (int ph = 0; ph < 6; ph++) begin
      settle();
      set_phase_regs(ph);
      run_phase(ph);
    end

    stop_input();
    wait_owed_empty();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && owed_samples.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // hard stop far beyond the slowest legal run
  initial begin
    #5000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
